>>> src/rbsi_pkg.sv
package rbsi_pkg;

    // coordinate format
    localparam int CW    = 32;
    localparam int FB    = 16;
    localparam int THR_W = 17;
    // quotient bits of 2^(2*FB) / d, partial remainder, plane offset, product widths
    localparam int QW    = 2 * FB + 1;
    localparam int RW    = CW + 1;
    localparam int DW    = CW + 1;
    localparam int PW    = 2 * CW + 1;

    localparam logic [CW-1:0] CW_MAX_V = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CW_MIN_V = {1'b1, {(CW-1){1'b0}}};

    // classified ray/box job handed from front to back
    typedef struct packed {
        logic                  in_box;
        logic [2:0]            par;
        logic [2:0][CW-1:0]    dmag;
        logic [2:0][CW-1:0]    org;
        logic [2:0][CW-1:0]    dir;
        logic [2:0][DW-1:0]    dlo;
        logic [2:0][DW-1:0]    dhi;
    } t_job;

    // one result transaction
    typedef struct packed {
        logic                  hit;
        logic [CW-1:0]         distance;
        logic [2:0][CW-1:0]    pt;
        logic                  in_box;
    } t_res;

    // clamp a wide signed value to the coordinate range
    function automatic logic [CW-1:0] sat_cw(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] hi_lim;
        logic signed [PW-1:0] lo_lim;
        hi_lim = {{(PW-CW){1'b0}}, CW_MAX_V};
        lo_lim = {{(PW-CW){1'b1}}, CW_MIN_V};
        if (v > hi_lim) begin
            return CW_MAX_V;
        end else if (v < lo_lim) begin
            return CW_MIN_V;
        end else begin
            return v[CW-1:0];
        end
    endfunction

endpackage

>>> src/rbsi_recip.sv
module rbsi_recip
    import rbsi_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [CW-1:0] i_dmag,
    output logic [QW-1:0] o_q
);

    logic [RW-1:0] r_rem [QW];
    logic [CW-1:0] r_d   [QW];
    logic [QW-1:0] r_q   [QW];

    // restoring divider of 2^(2*FB) by the magnitude, one quotient bit per stage
    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam logic NUM_BIT = (k == 0);
        logic [RW-1:0] rem_in;
        logic [CW-1:0] d_in;
        logic [QW-1:0] q_in;
        logic [RW-1:0] shifted;
        logic [RW:0]   trial;
        logic          qb;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign d_in   = i_dmag;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign d_in   = r_d[k-1];
            assign q_in   = r_q[k-1];
        end

        assign shifted = {rem_in[RW-2:0], NUM_BIT};
        assign trial   = {1'b0, shifted} - {{(RW+1-CW){1'b0}}, d_in};
        assign qb      = !trial[RW];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= qb ? trial[RW-1:0] : shifted;
                r_d[k]   <= d_in;
                r_q[k]   <= {q_in[QW-2:0], qb};
            end
        end
    end

    assign o_q = r_q[QW-1];

endmodule

>>> src/rbsi_queue.sv
module rbsi_queue
    import rbsi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_data
);

    t_job       r_mem [2];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       r_wr;
    logic       r_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd];

    // occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> src/rbsi_front.sv
module rbsi_front
    import rbsi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [THR_W-1:0]   i_thr,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0][CW-1:0] i_org,
    input  logic [2:0][CW-1:0] i_dir,
    input  logic [2:0][CW-1:0] i_lo,
    input  logic [2:0][CW-1:0] i_hi,
    output logic               o_job_valid,
    output t_job               o_job,
    input  logic               i_job_ready
);

    t_job       r_job;
    t_job       n_job;
    logic       r_v;
    logic [2:0] in_ax;
    logic       org_in;

    // inside test and slab setup per axis
    always_comb begin
        logic [CW-1:0] d;
        logic [CW-1:0] negd;
        logic [CW-1:0] tdir;
        logic [CW-1:0] mag;
        for (int a = 0; a < 3; a++) begin
            in_ax[a] = ($signed(i_org[a]) > $signed(i_lo[a])) &&
                       ($signed(i_org[a]) < $signed(i_hi[a]));
        end
        org_in = &in_ax;
        n_job  = '0;
        n_job.in_box = org_in;
        for (int a = 0; a < 3; a++) begin
            d    = i_dir[a];
            negd = (d == CW_MIN_V) ? CW_MAX_V : (~d + 1'b1);
            tdir = org_in ? negd : d;
            mag  = tdir[CW-1] ? (~tdir + 1'b1) : tdir;
            n_job.dir[a]  = tdir;
            n_job.dmag[a] = mag;
            n_job.par[a]  = (tdir == '0) || (mag < {{(CW-THR_W){1'b0}}, i_thr});
            n_job.org[a]  = i_org[a];
            n_job.dlo[a]  = {i_lo[a][CW-1], i_lo[a]} - {i_org[a][CW-1], i_org[a]};
            n_job.dhi[a]  = {i_hi[a][CW-1], i_hi[a]} - {i_org[a][CW-1], i_org[a]};
        end
    end

    assign o_ready     = !r_v || i_job_ready;
    assign o_job_valid = r_v;
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_job <= n_job;
        end
    end

endmodule

>>> src/rbsi_back.sv
module rbsi_back
    import rbsi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_job_valid,
    input  t_job i_job,
    output logic o_job_pop,
    input  logic i_out_ready,
    output logic o_out_valid,
    output t_res o_res
);

    logic                 en;
    logic                 take;
    logic [QW-1:0]        q [3];

    logic                 r_dv   [QW];
    t_job                 r_djob [QW];

    logic                 r_rv;
    t_job                 r_rjob;
    logic [CW-1:0]        r_rcp [3];
    logic [CW-1:0]        n_rcp [3];

    logic                 r_mv;
    t_job                 r_mjob;
    logic signed [PW-1:0] r_p0 [3];
    logic signed [PW-1:0] r_p1 [3];

    logic                 r_sv;
    t_job                 r_sjob;
    logic [CW-1:0]        r_t0 [3];
    logic [CW-1:0]        r_t1 [3];

    logic                 r_tv;
    t_job                 r_tjob;
    logic [CW-1:0]        r_tmin;
    logic                 r_hit;
    logic [CW-1:0]        n_tmin;
    logic                 n_hit;

    logic                   r_pv;
    t_job                   r_pjob;
    logic [CW-1:0]          r_ptmin;
    logic                   r_phit;
    logic signed [2*CW-1:0] r_pm [3];

    t_res                 n_res;
    logic                 push;
    logic                 pop;
    t_res                 r_omem [2];
    logic [1:0]           r_ocnt;
    logic                 r_owr;
    logic                 r_ord;

    // pipeline advances while the result buffer has a free slot
    assign en        = (r_ocnt != 2'd2);
    assign take      = en && i_job_valid;
    assign o_job_pop = take;

    // reciprocal units, one per axis
    for (genvar a = 0; a < 3; a++) begin : g_recip
        rbsi_recip u_recip (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_dmag (i_job.dmag[a]),
            .o_q    (q[a])
        );
    end

    // job travels alongside the divider
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_djob[0] <= i_job;
            for (int k = 1; k < QW; k++) begin
                r_djob[k] <= r_djob[k-1];
            end
        end
    end

    // signed, saturated reciprocal
    always_comb begin
        logic [CW-1:0] dsel;
        for (int a = 0; a < 3; a++) begin
            dsel = r_djob[QW-1].dir[a];
            if (r_djob[QW-1].par[a]) begin
                n_rcp[a] = CW_MAX_V;
            end else if (!dsel[CW-1]) begin
                n_rcp[a] = (q[a] > {{(QW-CW){1'b0}}, CW_MAX_V}) ? CW_MAX_V : q[a][CW-1:0];
            end else begin
                n_rcp[a] = (q[a] > {{(QW-CW){1'b0}}, CW_MIN_V}) ? CW_MIN_V :
                           (~q[a][CW-1:0] + 1'b1);
            end
        end
    end

    // entry and exit over all slabs
    always_comb begin
        logic [CW-1:0] nr;
        logic [CW-1:0] fr;
        logic [CW-1:0] tmax;
        n_tmin = '0;
        tmax   = '0;
        for (int a = 0; a < 3; a++) begin
            if ($signed(r_t0[a]) < $signed(r_t1[a])) begin
                nr = r_t0[a];
                fr = r_t1[a];
            end else begin
                nr = r_t1[a];
                fr = r_t0[a];
            end
            if (a == 0 || $signed(nr) > $signed(n_tmin)) begin
                n_tmin = nr;
            end
            if (a == 0 || $signed(fr) < $signed(tmax)) begin
                tmax = fr;
            end
        end
        n_hit = !tmax[CW-1] && ($signed(n_tmin) <= $signed(tmax));
    end

    // hit point and reported distance
    always_comb begin
        logic signed [PW-1:0] sh;
        logic [CW-1:0]        m;
        logic [DW-1:0]        sum;
        logic [DW-1:0]        nt;
        n_res        = '0;
        n_res.hit    = r_phit;
        n_res.in_box = r_pjob.in_box;
        for (int a = 0; a < 3; a++) begin
            sh  = $signed({r_pm[a][2*CW-1], r_pm[a]}) >>> FB;
            m   = sat_cw(sh);
            sum = {r_pjob.org[a][CW-1], r_pjob.org[a]} + {m[CW-1], m};
            n_res.pt[a] = sat_cw({{(PW-DW){sum[DW-1]}}, sum});
        end
        nt = ~{r_ptmin[CW-1], r_ptmin} + 1'b1;
        n_res.distance = r_pjob.in_box ? sat_cw({{(PW-DW){nt[DW-1]}}, nt}) : r_ptmin;
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rjob <= r_djob[QW-1];
            r_mjob <= r_rjob;
            r_sjob <= r_mjob;
            r_tjob <= r_sjob;
            r_pjob <= r_tjob;
            r_tmin <= n_tmin;
            r_hit  <= n_hit;
            r_ptmin <= r_tmin;
            r_phit  <= r_hit;
            for (int a = 0; a < 3; a++) begin
                r_rcp[a] <= n_rcp[a];
                r_p0[a]  <= $signed(r_rjob.dlo[a]) * $signed(r_rcp[a]);
                r_p1[a]  <= $signed(r_rjob.dhi[a]) * $signed(r_rcp[a]);
                r_t0[a]  <= sat_cw(r_p0[a] >>> FB);
                r_t1[a]  <= sat_cw(r_p1[a] >>> FB);
                r_pm[a]  <= $signed(r_tjob.dir[a]) * $signed(r_tmin);
            end
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QW; k++) begin
                r_dv[k] <= 1'b0;
            end
            r_rv <= 1'b0;
            r_mv <= 1'b0;
            r_sv <= 1'b0;
            r_tv <= 1'b0;
            r_pv <= 1'b0;
        end else if (en) begin
            r_dv[0] <= take;
            for (int k = 1; k < QW; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
            r_rv <= r_dv[QW-1];
            r_mv <= r_rv;
            r_sv <= r_mv;
            r_tv <= r_sv;
            r_pv <= r_tv;
        end
    end

    // result buffer decouples the output handshake from the pipeline
    assign push        = en && r_pv;
    assign pop         = (r_ocnt != 2'd0) && i_out_ready;
    assign o_out_valid = (r_ocnt != 2'd0);
    assign o_res       = r_omem[r_ord];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocnt <= 2'd0;
            r_owr  <= 1'b0;
            r_ord  <= 1'b0;
        end else begin
            if (push && !pop) begin
                r_ocnt <= r_ocnt + 2'd1;
            end else if (!push && pop) begin
                r_ocnt <= r_ocnt - 2'd1;
            end
            if (push) begin
                r_owr <= !r_owr;
            end
            if (pop) begin
                r_ord <= !r_ord;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_omem[r_owr] <= n_res;
        end
    end

endmodule

>>> src/ray_box_slab_intersect.sv
// ray / axis-aligned box slab test in signed Q16.16
// input channel: i_in_valid / o_in_ready with origin, direction and box corners;
// a transaction is taken on a rising edge where both are high
// output channel: o_out_valid / i_out_ready with hit, distance, hit point and
// the origin-inside flag, one result transaction per input transaction, in order
// configuration: APB-style write of parallel_threshold at byte address 0
// (17 bits, reset value 1); pready is tied high
// throughput: one transaction per cycle while the output is not stalled, set
// by a fully pipelined reciprocal divider of 33 stages (one quotient bit per
// stage) on each axis
// path from input acceptance to result: front register, 2-entry queue,
// 33 divider stages, 5 arithmetic stages, result buffer
// reset (synchronous, active low) empties every stage and both queues and
// restores the threshold; o_in_ready is high right after reset
// output stall: results collect in a 2-entry buffer; once it is full the back
// pipeline freezes, the middle queue fills and then o_in_ready drops
module ray_box_slab_intersect
    import rbsi_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [CW-1:0] i_origin_x,
    input  logic [CW-1:0] i_origin_y,
    input  logic [CW-1:0] i_origin_z,
    input  logic [CW-1:0] i_dir_x,
    input  logic [CW-1:0] i_dir_y,
    input  logic [CW-1:0] i_dir_z,
    input  logic [CW-1:0] i_box_min_x,
    input  logic [CW-1:0] i_box_min_y,
    input  logic [CW-1:0] i_box_min_z,
    input  logic [CW-1:0] i_box_max_x,
    input  logic [CW-1:0] i_box_max_y,
    input  logic [CW-1:0] i_box_max_z,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic          o_out_hit,
    output logic [CW-1:0] o_out_distance,
    output logic [CW-1:0] o_out_point_x,
    output logic [CW-1:0] o_out_point_y,
    output logic [CW-1:0] o_out_point_z,
    output logic          o_out_origin_inside
);

    localparam logic REG_THR = 1'b0;

    logic [THR_W-1:0] r_thr;
    logic             wr_en;
    logic             f_valid;
    t_job             f_job;
    logic             q_full;
    logic             q_valid;
    t_job             q_job;
    logic             q_pop;
    t_res             res;

    // configuration register
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= {{(THR_W-1){1'b0}}, 1'b1};
        end else if (wr_en && paddr[2] == REG_THR) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_THR) ? {{(32-THR_W){1'b0}}, r_thr} : 32'd0;

    // classify and set up slabs
    rbsi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_thr       (r_thr),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_org       ({i_origin_z, i_origin_y, i_origin_x}),
        .i_dir       ({i_dir_z, i_dir_y, i_dir_x}),
        .i_lo        ({i_box_min_z, i_box_min_y, i_box_min_x}),
        .i_hi        ({i_box_max_z, i_box_max_y, i_box_max_x}),
        .o_job_valid (f_valid),
        .o_job       (f_job),
        .i_job_ready (!q_full)
    );

    // short queue between front and back
    rbsi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid && !q_full),
        .i_data  (f_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_job)
    );

    // reciprocal, slab distances, hit point
    rbsi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_pop   (q_pop),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_res       (res)
    );

    assign o_out_hit           = res.hit;
    assign o_out_distance      = res.distance;
    assign o_out_point_x       = res.pt[0];
    assign o_out_point_y       = res.pt[1];
    assign o_out_point_z       = res.pt[2];
    assign o_out_origin_inside = res.in_box;

    // checks
    a_empty_after_reset: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    a_ready_after_reset: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> o_in_ready)
        else $error("input not ready right after reset");

    a_thr_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en && paddr[2] == REG_THR |=> r_thr == $past(pwdata[THR_W-1:0]))
        else $error("threshold write lost");

endmodule

>>> dv/ray_box_slab_intersect_checker.sv
`timescale 1ns / 1ps

module ray_box_slab_intersect_checker
    import rbsi_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    input  logic          pready,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  logic [11:0][CW-1:0] i_ray_box,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  t_res          i_res,
    output int            o_pending,
    output int            o_errors
);

    localparam logic [2:0] ADDR_THRESHOLD = 3'd0;
    localparam longint     Q_MAX = 64'sd2147483647;
    localparam longint     Q_MIN = -64'sd2147483648;

    logic [THR_W-1:0] thr;
    t_res             slab_results[$];

    function automatic longint clamp_q(input longint v);
        if (v > Q_MAX) begin
            return Q_MAX;
        end else if (v < Q_MIN) begin
            return Q_MIN;
        end
        return v;
    endfunction

    // fixed-point product, floor shift, clamp
    function automatic longint fx_prod(input longint a, input longint b);
        longint p;
        p = a * b;
        return clamp_q(p >>> FB);
    endfunction

    function automatic longint inv_dir(input longint d, input logic [THR_W-1:0] th);
        longint mag;
        mag = (d < 0) ? -d : d;
        if (d == 0 || mag < longint'(th)) begin
            return Q_MAX;
        end
        return clamp_q((64'sd1 <<< (2 * FB)) / d);
    endfunction

    // slab test on one ray/box pair
    function automatic t_res slab_predict(input logic [11:0][CW-1:0] rb,
                                          input logic [THR_W-1:0] th);
        longint o[3], d[3], lo[3], hi[3];
        longint r, t0, t1, tmin, tmax;
        bit     ins;
        t_res   res;
        ins = 1'b1;
        for (int a = 0; a < 3; a++) begin
            o[a]  = longint'(signed'(rb[a]));
            d[a]  = longint'(signed'(rb[3+a]));
            lo[a] = longint'(signed'(rb[6+a]));
            hi[a] = longint'(signed'(rb[9+a]));
            if (!(o[a] > lo[a] && o[a] < hi[a])) ins = 1'b0;
        end
        // origin inside: test runs with the reversed direction
        if (ins) begin
            for (int a = 0; a < 3; a++) d[a] = clamp_q(-d[a]);
        end
        tmin = Q_MIN;
        tmax = Q_MAX;
        for (int a = 0; a < 3; a++) begin
            r  = inv_dir(d[a], th);
            t0 = fx_prod(lo[a] - o[a], r);
            t1 = fx_prod(hi[a] - o[a], r);
            if (a == 0) begin
                tmin = (t0 < t1) ? t0 : t1;
                tmax = (t0 > t1) ? t0 : t1;
            end else begin
                tmin = ((t0 < t1 ? t0 : t1) > tmin) ? (t0 < t1 ? t0 : t1) : tmin;
                tmax = ((t0 > t1 ? t0 : t1) < tmax) ? (t0 > t1 ? t0 : t1) : tmax;
            end
        end
        res.hit = (tmax >= 0) && (tmin <= tmax);
        for (int a = 0; a < 3; a++) begin
            res.pt[a] = CW'(clamp_q(o[a] + fx_prod(d[a], tmin)));
        end
        res.distance = CW'(ins ? clamp_q(-tmin) : tmin);
        res.in_box   = ins;
        return res;
    endfunction

    assign o_pending = slab_results.size();

    // track threshold writes, predict on input transactions, compare outputs
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            thr <= THR_W'(1);
            slab_results.delete();
            o_errors <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_THRESHOLD) begin
                thr <= pwdata[THR_W-1:0];
            end
            if (i_in_valid && i_in_ready) begin
                slab_results.push_back(slab_predict(i_ray_box, thr));
            end
            if (i_out_valid && i_out_ready) begin
                if (slab_results.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result transaction %p", i_res);
                    o_errors <= o_errors + 1;
                end else begin
                    want = slab_results.pop_front();
                    if (want !== i_res) begin
                        if (o_errors < 10) begin
                            $display("mismatch: hit %0b/%0b dist %h/%h pt %h %h %h / %h %h %h",
                                     want.hit, i_res.hit, want.distance, i_res.distance,
                                     want.pt[0], want.pt[1], want.pt[2],
                                     i_res.pt[0], i_res.pt[1], i_res.pt[2]);
                            $display("          inside %0b/%0b", want.in_box, i_res.in_box);
                        end
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

>>> dv/ray_box_slab_intersect_tb.sv
`timescale 1ns / 1ps

module ray_box_slab_intersect_tb;
    import rbsi_pkg::*;

    localparam logic [2:0] ADDR_THRESHOLD = 3'd0;
    localparam int         N_RANDOM = 880;
    localparam int         DRAIN_CYCLES = 50;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic        in_valid, in_ready, out_valid, out_ready;
    logic [11:0][CW-1:0] ray_box;
    t_res        res;
    int          pending, errors;
    int          tx_idle, rx_idle, rx_hold;
    int          sent;

    ray_box_slab_intersect dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_origin_x(ray_box[0]), .i_origin_y(ray_box[1]), .i_origin_z(ray_box[2]),
        .i_dir_x(ray_box[3]), .i_dir_y(ray_box[4]), .i_dir_z(ray_box[5]),
        .i_box_min_x(ray_box[6]), .i_box_min_y(ray_box[7]), .i_box_min_z(ray_box[8]),
        .i_box_max_x(ray_box[9]), .i_box_max_y(ray_box[10]), .i_box_max_z(ray_box[11]),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_out_hit(res.hit), .o_out_distance(res.distance),
        .o_out_point_x(res.pt[0]), .o_out_point_y(res.pt[1]), .o_out_point_z(res.pt[2]),
        .o_out_origin_inside(res.in_box)
    );

    ray_box_slab_intersect_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_ray_box(ray_box),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_res(res),
        .o_pending(pending), .o_errors(errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("ray_box_slab_intersect_tb failed");
        $finish;
    end

    // receiver: random stalls plus a long hold-off on request
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            out_ready <= 1'b0;
            rx_hold   <= rx_hold - 1;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // let the pipeline empty before touching the register
    task automatic wait_idle();
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_ray(input logic [11:0][CW-1:0] rb);
        bit took;
        if ($urandom_range(99) < tx_idle) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        ray_box  <= rb;
        in_valid <= 1'b1;
        do begin
            @(negedge i_clk);
            took = in_ready;
            @(posedge i_clk);
        end while (!took);
        sent++;
    endtask

    function automatic logic [CW-1:0] any_coord();
        case ($urandom_range(7))
            0: return CW_MIN_V;
            1: return CW_MAX_V;
            2: return '0;
            3: return CW'($urandom_range(140000)) * (($urandom_range(1)) ? 1 : -1);
            default: return $urandom;
        endcase
    endfunction

    // mostly boxes of sane size with rays aimed around them
    function automatic logic [11:0][CW-1:0] random_ray();
        logic [11:0][CW-1:0] rb;
        int c, h, kind;
        kind = $urandom_range(9);
        for (int a = 0; a < 3; a++) begin
            c = int'($urandom_range(40 << 16)) - (20 << 16);
            h = int'($urandom_range(1, 8 << 16));
            rb[6+a] = c - h;
            rb[9+a] = c + h;
            if (kind < 4) rb[a] = c + int'($urandom_range(2 * h - 2)) - h + 1;
            else rb[a] = int'($urandom_range(80 << 16)) - (40 << 16);
            case ($urandom_range(5))
                0: rb[3+a] = int'($urandom_range(140000)) - 70000;
                1: rb[3+a] = int'($urandom_range(8)) - 4;
                2: rb[3+a] = any_coord();
                default: rb[3+a] = int'($urandom_range(8 << 16)) - (4 << 16);
            endcase
        end
        if (kind == 9) begin
            for (int i = 0; i < 12; i++) rb[i] = any_coord();
        end
        return rb;
    endfunction

    function automatic logic [11:0][CW-1:0] make_ray(input int ox, oy, oz, dx, dy, dz,
                                                     input int lx, ly, lz, hx, hy, hz);
        return {hz, hy, hx, lz, ly, lx, dz, dy, dx, oz, oy, ox};
    endfunction

    task automatic directed_rays();
        int one, mn, mx;
        one = 1 << 16;
        mn  = int'(CW_MIN_V);
        mx  = int'(CW_MAX_V);
        send_ray('0);
        send_ray({12{CW_MAX_V}});
        send_ray({12{CW_MIN_V}});
        send_ray({6{32'hAAAA_AAAA, 32'h5555_5555}});
        send_ray({6{32'h5555_5555, 32'hAAAA_AAAA}});
        // reversed minimum: inside, most negative direction
        send_ray(make_ray(0, 0, 0, mn, mn, mn, -10*one, -10*one, -10*one,
                          10*one, 10*one, 10*one));
        // negated minimum: inside with tiny direction drives entry to the floor
        send_ray(make_ray(0, 0, 0, -1, -1, -1, -1000*one, -1000*one, -1000*one,
                          1000*one, 1000*one, 1000*one));
        // zero direction components
        send_ray(make_ray(-5*one, 0, 0, one, 0, 0, -one, -one, -one, one, one, one));
        send_ray(make_ray(-5*one, 3*one, 0, one, 0, 0, -one, -one, -one, one, one, one));
        // hit, miss, behind, negative direction
        send_ray(make_ray(-5*one, -4*one, 0, one, one, 0, -one, -one, -one, one, one, one));
        send_ray(make_ray(-5*one, 0, 0, -one, 0, 0, -one, -one, -one, one, one, one));
        send_ray(make_ray(5*one, one/2, 0, -one, 0, one/8, -one, -one, -one,
                          one, one, one));
        send_ray(make_ray(mn, mn, mn, mx, mx, mx, mn, mn, mn, mx, mx, mx));
        send_ray(make_ray(mx, mx, mx, mn, mn, mn, mn, mn, mn, mx, mx, mx));
        send_ray(make_ray(0, 0, 0, 2, -2, 1, mn, mn, mn, mx, mx, mx));
        send_ray(make_ray(one, one, one, 65535, 65536, 65537, 0, 0, 0,
                          2*one, 2*one, 2*one));
        send_ray(make_ray(-one, 0, 0, 999, -1000, 1001, -one/2, -one/2, -one/2,
                          one/2, one/2, one/2));
    endtask

    task automatic random_rays(input int n);
        for (int i = 0; i < n; i++) begin
            // idling profile follows the overall number of rays sent so far
            if (sent < N_RANDOM / 3) begin
                tx_idle = 35; rx_idle = 67;
            end else if (sent < 2 * N_RANDOM / 3) begin
                tx_idle = 67; rx_idle = 35;
            end else begin
                tx_idle = 0;  rx_idle = 0;
            end
            send_ray(random_ray());
        end
        in_valid <= 1'b0;
    endtask

    initial begin
        i_rst_n  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        ray_box  = '0;
        out_ready = 1'b0;
        tx_idle  = 0;
        rx_idle  = 0;
        rx_hold  = 0;
        sent     = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset threshold
        directed_rays();
        random_rays(150);
        wait_idle();

        cfg_write(ADDR_THRESHOLD, 32'd0);
        directed_rays();
        // long receiver hold-off while rays keep coming
        rx_hold = 300;
        tx_idle = 0;
        random_rays(150);
        wait_idle();

        cfg_write(ADDR_THRESHOLD, 32'd65536);
        directed_rays();
        random_rays(200);
        wait_idle();

        cfg_write(ADDR_THRESHOLD, 32'hFFFF_FFFF);
        random_rays(150);
        wait_idle();

        cfg_write(ADDR_THRESHOLD, 32'd1000);
        random_rays(230);
        wait_idle();

        if (errors == 0) begin
            $display("ray_box_slab_intersect_tb passed");
        end else begin
            $display("ray_box_slab_intersect_tb failed");
        end
        $finish;
    end

endmodule

>>> files.f
src/rbsi_pkg.sv
src/rbsi_recip.sv
src/rbsi_queue.sv
src/rbsi_front.sv
src/rbsi_back.sv
src/ray_box_slab_intersect.sv
dv/ray_box_slab_intersect_checker.sv
dv/ray_box_slab_intersect_tb.sv
